### sv/tube_strip_vertex_generator_defines.svh
// Assertion macros shared by the checker.
`ifndef TUBE_STRIP_VERTEX_GENERATOR_DEFINES_SVH
`define TUBE_STRIP_VERTEX_GENERATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TSVG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked on the following clock edge
`define TSVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/tsvg_pkg.sv
// Package: types, constants and tables for the tube strip vertex generator.
package tsvg_pkg;
	localparam int COORD_W = 16;
	localparam int ACC_W   = 34;
	localparam int COORD_FRAC_BITS = 12;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

	typedef enum logic [1:0] {
		CFG_SEGMENTS   = 2'd0,
		CFG_AXIS_ORDER = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQRT, ST_DIVX, ST_DIVR, ST_PHASE, ST_CORDIC,
		ST_GAIN, ST_MUL, ST_OUT, ST_BAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sqrt_start;
		logic divx_start;
		logic divr_start;
		logic phase_start;
		logic cordic_start;
		logic gain;
		logic mul;
		logic emit;
		logic emit_bad;
		logic next_col;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic degenerate;
		logic busy;
		logic last_col;
	} dp_sts_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0:  atan_turn = 32'd536870912;
			5'd1:  atan_turn = 32'd316933406;
			5'd2:  atan_turn = 32'd167458907;
			5'd3:  atan_turn = 32'd85004755;
			5'd4:  atan_turn = 32'd42667330;
			5'd5:  atan_turn = 32'd21354465;
			5'd6:  atan_turn = 32'd10679838;
			5'd7:  atan_turn = 32'd5340245;
			5'd8:  atan_turn = 32'd2670163;
			5'd9:  atan_turn = 32'd1335087;
			5'd10: atan_turn = 32'd667544;
			5'd11: atan_turn = 32'd333772;
			5'd12: atan_turn = 32'd166886;
			5'd13: atan_turn = 32'd83443;
			5'd14: atan_turn = 32'd41722;
			5'd15: atan_turn = 32'd20861;
			5'd16: atan_turn = 32'd10430;
			5'd17: atan_turn = 32'd5215;
			5'd18: atan_turn = 32'd2608;
			5'd19: atan_turn = 32'd1304;
			5'd20: atan_turn = 32'd652;
			5'd21: atan_turn = 32'd326;
			5'd22: atan_turn = 32'd163;
			5'd23: atan_turn = 32'd81;
			default: atan_turn = 32'd0;
		endcase
	endfunction
endpackage

### sv/tsvg_if.sv
// Valid/ready channel interfaces for tube descriptions and vertex columns.
interface tsvg_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] near_axial;
	logic signed [15:0] near_radius;
	logic signed [15:0] far_axial;
	logic signed [15:0] far_radius;
	logic signed [15:0] centre_second;
	logic signed [15:0] centre_third;
	modport source (output valid, near_axial, near_radius, far_axial, far_radius,
		centre_second, centre_third, input ready);
	modport sink (input valid, near_axial, near_radius, far_axial, far_radius,
		centre_second, centre_third, output ready);
endinterface

interface tsvg_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] near_x;
	logic signed [15:0] near_y;
	logic signed [15:0] near_z;
	logic signed [15:0] far_x;
	logic signed [15:0] far_y;
	logic signed [15:0] far_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic last;
	logic bad_args;
	modport source (output valid, near_x, near_y, near_z, far_x, far_y, far_z,
		norm_x, norm_y, norm_z, last, bad_args, input ready);
	modport sink (input valid, near_x, near_y, near_z, far_x, far_y, far_z,
		norm_x, norm_y, norm_z, last, bad_args, output ready);
endinterface

### sv/tube_strip_vertex_generator.sv
// Top level: tube strip vertex generator, configuration registers and wiring.
//
//  channel | dir | payload
//  in      | in  | near/far axial and radius, centre offsets (6 x Q3.12)
//  out     | out | near/far ring vertex, normal (Q1.14), last, bad_args
//  cfg     | in  | index 0 segments, index 1 axis_order
//
// Sequence: a tube runs a square root and two divides on the shared iterative
// unit, then each column runs a phase division, the CORDIC rotation, the gain
// scaling, the product step and the output transfer. Bad tubes skip all of
// this and go straight to a bad_args result.
// Reset clears the controller, column count and normal parts; one tube
// is in flight at a time and a stalled output holds the column.
module tube_strip_vertex_generator import tsvg_pkg::*; #(
	parameter int MAX_SEGMENTS     = 63,
	parameter int ANGLE_ITERATIONS = 16
) (
	input logic        clk,
	input logic        arst_n,
	tsvg_in_if.sink    in_ch,
	tsvg_out_if.source out_ch,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [5:0]  cfg_wdata
);
	logic [5:0] segments_q;
	logic [1:0] axis_order_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic signed [15:0] g_in [6];
	logic signed [15:0] res [9];
	logic res_last;
	logic seg_bad;
	logic [5:0] seg_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q   <= 6'd8;
			axis_order_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEGMENTS:   segments_q   <= cfg_wdata;
				CFG_AXIS_ORDER: axis_order_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// segment count saturates to the build limit; three or more needed
	assign seg_c   = (segments_q > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS) : segments_q;
	assign seg_bad = (seg_c <= 6'd2);

	assign g_in = '{in_ch.near_axial, in_ch.near_radius, in_ch.far_axial,
		in_ch.far_radius, in_ch.centre_second, in_ch.centre_third};

	tsvg_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (in_ch.valid), .in_ready (in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.seg_bad, .sts, .cmd
	);

	tsvg_dp #(
		.MAX_SEGMENTS(MAX_SEGMENTS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.seg(segments_q), .axis_order(axis_order_q),
		.g_in, .res, .res_last
	);

	assign out_ch.near_x   = res[0];
	assign out_ch.near_y   = res[1];
	assign out_ch.near_z   = res[2];
	assign out_ch.far_x    = res[3];
	assign out_ch.far_y    = res[4];
	assign out_ch.far_z    = res[5];
	assign out_ch.norm_x   = res[6];
	assign out_ch.norm_y   = res[7];
	assign out_ch.norm_z   = res[8];
	assign out_ch.last     = res_last;
	assign out_ch.bad_args = cmd.emit_bad;
endmodule

### sv/tsvg_ctrl.sv
// Controller state machine sequencing the per-tube and per-column work.
module tsvg_ctrl import tsvg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    seg_bad,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (seg_bad || sts.degenerate) begin
					state_d = ST_BAD;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_DIVX;
				end
			end
			ST_DIVX: begin
				if (!sts.busy) begin
					cmd.divx_start = 1'b1;
					state_d = ST_DIVR;
				end
			end
			ST_DIVR: begin
				if (!sts.busy) begin
					cmd.divr_start = 1'b1;
					state_d = ST_PHASE;
				end
			end
			ST_PHASE: begin
				if (!sts.busy) begin
					cmd.phase_start = 1'b1;
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (!sts.busy) begin
					cmd.cordic_start = 1'b1;
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				if (!sts.busy) begin
					cmd.gain = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!sts.busy) begin
					cmd.mul = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.emit  = 1'b1;
				if (out_ready) begin
					if (sts.last_col) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_col = 1'b1;
						state_d = ST_PHASE;
					end
				end
			end
			ST_BAD: begin
				out_valid    = 1'b1;
				cmd.emit_bad = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### sv/tsvg_dp.sv
// Datapath: square root, divider, CORDIC and vertex/normal products.
module tsvg_dp import tsvg_pkg::*; #(
	parameter int MAX_SEGMENTS     = 63,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [5:0]         seg,
	input  logic [1:0]         axis_order,
	input  logic signed [15:0] g_in [6],
	output logic signed [15:0] res [9],
	output logic               res_last
);
	localparam int IT_W = $clog2(ANGLE_ITERATIONS + 1);

	logic signed [15:0] geo_q [6];
	logic signed [16:0] dx_q, dr_q;
	logic [5:0]  col_q;
	logic signed [15:0] axn_q, radn_q;

	// shared iterative unit
	typedef enum logic [2:0] {U_NONE, U_SQRT, U_DIV, U_PHASE, U_CORDIC, U_GAIN}
		unit_t;
	unit_t unit_q;
	logic [5:0] cnt_q;
	logic [63:0] rem_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;
	logic [33:0] h_q;
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic        div_r_q;
	logic        div_neg_q;
	logic [31:0] phase_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [IT_W-1:0] it_q;
	logic signed [67:0] gprod_q;
	logic signed [33:0] sn_q, cs_q;
	logic signed [50:0] v_s1 [4];
	logic signed [49:0] n_s1 [2];

	// divider operand: numerator bits are shifted in from an extended register
	logic [47:0] div_src_q;
	logic [47:0] dsrc;

	logic signed [33:0] dxs, dys;
	logic [33:0] sum_sq;
	logic [32:0] dx_m, dr_m;
	logic [64:0] trial;
	logic [48:0] dtrial;
	logic [5:0]  seg_c;

	assign seg_c = (seg > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS) : seg;
	assign dx_m = dx_q[16] ? 33'(-dx_q) : 33'(dx_q);
	assign dr_m = dr_q[16] ? 33'(-dr_q) : 33'(dr_q);
	assign dxs = cy_q >>> it_q;
	assign dys = cx_q >>> it_q;
	assign trial = {1'b0, rem_q} - {1'b0, root_q + bit_q};
	assign dsrc = (unit_q == U_PHASE) ? 48'(seg_c) : 48'(h_q);
	assign dtrial = {num_q, div_src_q[47]} - {1'b0, dsrc};

	assign sts.degenerate = (dx_q == '0) && (dr_q == '0);
	assign sts.busy = (unit_q != U_NONE);
	assign sts.last_col = (col_q == seg_c);

	function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
		if (v > 51'sd32767) sat16 = 16'sh7fff;
		else if (v < -51'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	function automatic logic signed [15:0] sat_q14(input logic [47:0] q);
		sat_q14 = (q > 48'd16384) ? ONE_Q14 : 16'(q);
	endfunction

	logic signed [33:0] gsum;
	logic signed [33:0] gclamp;
	assign gsum = 34'(gprod_q >>> 30);
	assign gclamp = (gsum > ONE_Q30) ? ONE_Q30 : ((gsum < -ONE_Q30) ? -ONE_Q30 : gsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= U_NONE;
			cnt_q  <= '0;
			col_q  <= '0;
			axn_q  <= '0;
			radn_q <= '0;
			it_q   <= '0;
		end else begin
			case (unit_q)
				U_SQRT: begin
					// one result bit per cycle, classic digit-by-digit root
					if (bit_q == '0) begin
						h_q    <= (root_q[33:0] == '0) ? 34'd1 : root_q[33:0];
						unit_q <= U_NONE;
					end else begin
						if (!trial[64]) begin
							rem_q  <= trial[63:0];
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				U_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (!dtrial[48]) begin
						num_q <= dtrial[47:0];
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						num_q <= {num_q[46:0], div_src_q[47]};
						quo_q <= {quo_q[46:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) unit_q <= U_NONE;
				end
				U_PHASE: begin
					// floor(j*2^32/seg): divide col<<32 by seg, bit per cycle
					if (!dtrial[48]) begin
						num_q <= dtrial[47:0];
						phase_q <= {phase_q[30:0], 1'b1};
					end else begin
						num_q <= {num_q[46:0], div_src_q[47]};
						phase_q <= {phase_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) unit_q <= U_NONE;
				end
				U_CORDIC: begin
					if (it_q == IT_W'(ANGLE_ITERATIONS)) begin
						unit_q <= U_NONE;
					end else begin
						if (!cz_q[33]) begin
							cx_q <= cx_q - dxs;
							cy_q <= cy_q + dys;
							cz_q <= cz_q - 34'($signed({2'b0, atan_turn(5'(it_q))}));
						end else begin
							cx_q <= cx_q + dxs;
							cy_q <= cy_q - dys;
							cz_q <= cz_q + 34'($signed({2'b0, atan_turn(5'(it_q))}));
						end
						it_q <= it_q + IT_W'(1);
					end
				end
				U_GAIN: begin
					// cos product, then sin product, then the quadrant fold
					if (cnt_q == 6'd0) begin
						gprod_q <= cy_q * GAIN_Q30 + 68'(ONE_Q30 >>> 1);
						cnt_q   <= 6'd1;
						cs_q    <= gclamp;
					end else if (cnt_q == 6'd1) begin
						cnt_q <= 6'd2;
						sn_q  <= gclamp;
					end else begin
						unit_q <= U_NONE;
						case (phase_q[31:30])
							2'd1: begin cs_q <= -sn_q; sn_q <= cs_q; end
							2'd2: begin cs_q <= -cs_q; sn_q <= -sn_q; end
							2'd3: begin cs_q <= sn_q; sn_q <= -cs_q; end
							default: ;
						endcase
					end
				end
				default: ;
			endcase

			if (unit_q == U_DIV && cnt_q == 6'd0) begin
				// quotient complete, round already folded into numerator
				if (div_r_q) begin
					axn_q <= div_neg_q ? -sat_q14(dtrial[48] ? {quo_q[46:0], 1'b0}
						: {quo_q[46:0], 1'b1}) : sat_q14(dtrial[48] ?
						{quo_q[46:0], 1'b0} : {quo_q[46:0], 1'b1});
				end else begin
					radn_q <= div_neg_q ? -sat_q14(dtrial[48] ? {quo_q[46:0], 1'b0}
						: {quo_q[46:0], 1'b1}) : sat_q14(dtrial[48] ?
						{quo_q[46:0], 1'b0} : {quo_q[46:0], 1'b1});
				end
			end

			if (cmd.load) begin
				col_q <= '0;
			end
			if (cmd.next_col) begin
				col_q <= col_q + 6'd1;
			end
			if (cmd.sqrt_start) begin
				unit_q <= U_SQRT;
				rem_q  <= 64'(sum_sq) << 28;
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
			end
			if (cmd.divx_start || cmd.divr_start) begin
				unit_q    <= U_DIV;
				cnt_q     <= 6'd47;
				num_q     <= '0;
				quo_q     <= '0;
				div_r_q   <= cmd.divr_start;
				div_neg_q <= cmd.divr_start ? !dr_q[16] && dr_q != '0 : dx_q[16];
			end
			if (cmd.phase_start) begin
				// closing column wraps to a zero turn fraction
				unit_q  <= U_PHASE;
				cnt_q   <= 6'd31;
				num_q   <= sts.last_col ? 48'd0 : 48'(col_q);
				phase_q <= '0;
			end
			if (cmd.cordic_start) begin
				unit_q <= U_CORDIC;
				it_q   <= '0;
				cx_q   <= ONE_Q30;
				cy_q   <= '0;
				cz_q   <= 34'({2'b0, phase_q[29:0]});
			end
			if (cmd.gain) begin
				unit_q  <= U_GAIN;
				cnt_q   <= 6'd0;
				gprod_q <= cx_q * GAIN_Q30 + 68'(ONE_Q30 >>> 1);
			end
		end
	end

	// restoring step, divisor per unit; dividend streamed from div_src_q
	always_ff @(posedge clk) begin
		if (cmd.divx_start || cmd.divr_start) begin
			div_src_q <= ((cmd.divr_start ? 48'(dr_m) : 48'(dx_m)) << 28)
				+ 48'(h_q >> 1);
		end else if (cmd.phase_start) begin
			div_src_q <= '0;
		end else if (unit_q == U_DIV || unit_q == U_PHASE) begin
			div_src_q <= div_src_q << 1;
		end
	end

	// squared sum of deltas, 34 bits
	assign sum_sq = 34'(dx_m * dx_m) + 34'(dr_m * dr_m);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 6; k++) geo_q[k] <= g_in[k];
			dx_q <= 17'(g_in[2]) - 17'(g_in[0]);
			dr_q <= 17'(g_in[3]) - 17'(g_in[1]);
		end
		if (cmd.mul) begin
			v_s1[0] <= 51'(geo_q[1] * sn_q) + 51'(ONE_Q30 >>> 1);
			v_s1[1] <= 51'(geo_q[1] * cs_q) + 51'(ONE_Q30 >>> 1);
			v_s1[2] <= 51'(geo_q[3] * sn_q) + 51'(ONE_Q30 >>> 1);
			v_s1[3] <= 51'(geo_q[3] * cs_q) + 51'(ONE_Q30 >>> 1);
			n_s1[0] <= 50'(sn_q * radn_q) + 50'(ONE_Q30 >>> 1);
			n_s1[1] <= 50'(cs_q * radn_q) + 50'(ONE_Q30 >>> 1);
		end
	end

	logic signed [15:0] nv [3], fv [3], nn [3];
	logic signed [19:0] nr0, nr1;
	assign nr0 = 20'(n_s1[0] >>> 30);
	assign nr1 = 20'(n_s1[1] >>> 30);

	always_comb begin
		logic signed [15:0] a_n, b_n, c_n, a_f, b_f, c_f, a_m, b_m, c_m;
		a_n = geo_q[0];
		b_n = sat16(51'(geo_q[4]) + (v_s1[0] >>> 30));
		c_n = sat16(51'(geo_q[5]) + (v_s1[1] >>> 30));
		a_f = geo_q[2];
		b_f = sat16(51'(geo_q[4]) + (v_s1[2] >>> 30));
		c_f = sat16(51'(geo_q[5]) + (v_s1[3]  >>> 30));
		a_m = axn_q;
		b_m = (nr0 > 20'sd16384) ? ONE_Q14 : (nr0 < -20'sd16384) ? -ONE_Q14 : nr0[15:0];
		c_m = (nr1 > 20'sd16384) ? ONE_Q14 : (nr1 < -20'sd16384) ? -ONE_Q14 : nr1[15:0];
		case (axis_order)
			2'd1: begin
				nv = '{c_n, a_n, b_n}; fv = '{c_f, a_f, b_f}; nn = '{c_m, a_m, b_m};
			end
			2'd2: begin
				nv = '{b_n, c_n, a_n}; fv = '{b_f, c_f, a_f}; nn = '{b_m, c_m, a_m};
			end
			default: begin
				nv = '{a_n, b_n, c_n}; fv = '{a_f, b_f, c_f}; nn = '{a_m, b_m, c_m};
			end
		endcase
		for (int k = 0; k < 9; k++) res[k] = '0;
		res_last = 1'b1;
		if (cmd.emit) begin
			for (int k = 0; k < 3; k++) begin
				res[k] = nv[k]; res[3+k] = fv[k]; res[6+k] = nn[k];
			end
			res_last = sts.last_col;
		end
	end
endmodule

### sv/tsvg_checker.sv
// Port-level checker for the tube strip vertex generator, with its bind.
`include "tube_strip_vertex_generator_defines.svh"
module tsvg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_bad
);
	`TSVG_ASSERT_IMPL(a_bad_is_last, out_valid && out_bad, out_last, "bad result not last")
	`TSVG_ASSERT_IMPL(a_no_take_busy, out_valid, !in_ready, "input taken while emitting")
	`TSVG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn")
	`TSVG_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "second tube accepted")
endmodule

bind tube_strip_vertex_generator tsvg_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.last), .out_bad(out_ch.bad_args)
);

### test/tsvg_column_checker.sv
// Column checker: watches both channels, predicts every ring column and compares.
module tsvg_column_checker import tsvg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tsvg_in_if   in_ch,
	tsvg_out_if  out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_wdata,
	output int         mismatches,
	output int         columns_due
);
	localparam longint HALF_Q30 = 64'sd536870912;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint GAIN     = 64'sd652032874;
	localparam longint UNIT_Q14 = 64'sd16384;
	localparam int MAX_SEG = 63;

	typedef struct {
		logic [15:0] near_x, near_y, near_z;
		logic [15:0] far_x, far_y, far_z;
		logic [15:0] norm_x, norm_y, norm_z;
		logic last, bad_args;
	} column_t;

	localparam longint TURN_ATAN [16] = '{536870912, 316933406, 167458907, 85004755,
		42667330, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	logic [5:0] seg_cfg;
	logic [1:0] axis_cfg;
	column_t    column_q[$];

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint normal_share(longint num, longint unsigned h);
		longint unsigned m, q;
		m = num < 0 ? -num : num;
		q = ((m << 28) + (h >> 1)) / h;
		if (q > UNIT_Q14)
			q = UNIT_Q14;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	// rotation-mode CORDIC over one quadrant, then quadrant fold
	function automatic void angle_sin_cos(input logic [31:0] phase,
		output longint sn, output longint cs);
		longint x, y, z, dx, dy, t;
		x = UNIT_Q30;
		y = 0;
		z = longint'(phase[29:0]);
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= TURN_ATAN[i];
			end else begin
				x += dx; y -= dy; z += TURN_ATAN[i];
			end
		end
		cs = clip((x * GAIN + HALF_Q30) >>> 30, -UNIT_Q30, UNIT_Q30);
		sn = clip((y * GAIN + HALF_Q30) >>> 30, -UNIT_Q30, UNIT_Q30);
		case (phase[31:30])
			2'd1: begin t = cs; cs = -sn; sn = t; end
			2'd2: begin cs = -cs; sn = -sn; end
			2'd3: begin t = cs; cs = sn; sn = -t; end
			default: ;
		endcase
	endfunction

	function automatic longint ring_coord(longint centre, longint r, longint trig);
		return clip(centre + ((r * trig + HALF_Q30) >>> 30), -32768, 32767);
	endfunction

	function automatic void predict_tube(input longint x1, r1, x2, r2, cy, cz);
		column_t col;
		int seg, ia, ib, ic;
		longint dx, dr, axn, radn, s, c;
		longint nv[3], fv[3], nn[3];
		longint unsigned h;
		logic [31:0] phase;
		seg = seg_cfg > MAX_SEG ? MAX_SEG : seg_cfg;
		col = '{default: '0};
		if (seg <= 2 || (x1 == x2 && r1 == r2)) begin
			col.last = 1'b1;
			col.bad_args = 1'b1;
			column_q.insert(column_q.size(), col);
			return;
		end
		ia = 0; ib = 1; ic = 2;
		if (axis_cfg == 2'd1) begin
			ia = 1; ib = 2; ic = 0;
		end else if (axis_cfg == 2'd2) begin
			ia = 2; ib = 0; ic = 1;
		end
		dx = x2 - x1;
		dr = r2 - r1;
		h = root_floor((longint'(dx * dx) + longint'(dr * dr)) << 28);
		if (h == 0)
			h = 1;
		radn = normal_share(dx, h);
		axn = -normal_share(dr, h);
		for (int j = 0; j <= seg; j++) begin
			phase = 32'((longint'(j) << 32) / seg);
			angle_sin_cos(phase, s, c);
			nv[ia] = x1;
			nv[ib] = ring_coord(cy, r1, s);
			nv[ic] = ring_coord(cz, r1, c);
			fv[ia] = x2;
			fv[ib] = ring_coord(cy, r2, s);
			fv[ic] = ring_coord(cz, r2, c);
			nn[ia] = axn;
			nn[ib] = clip((s * radn + HALF_Q30) >>> 30, -UNIT_Q14, UNIT_Q14);
			nn[ic] = clip((c * radn + HALF_Q30) >>> 30, -UNIT_Q14, UNIT_Q14);
			col.near_x = 16'(nv[0]); col.near_y = 16'(nv[1]); col.near_z = 16'(nv[2]);
			col.far_x = 16'(fv[0]); col.far_y = 16'(fv[1]); col.far_z = 16'(fv[2]);
			col.norm_x = 16'(nn[0]); col.norm_y = 16'(nn[1]); col.norm_z = 16'(nn[2]);
			col.last = (j == seg);
			col.bad_args = 1'b0;
			column_q.insert(column_q.size(), col);
		end
	endfunction

	function automatic int field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v === act_v)
			return 0;
		$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		column_t e;
		int bad;
		if (!arst_n) begin
			seg_cfg <= 6'd8;
			axis_cfg <= 2'd0;
			mismatches <= 0;
		end else begin
			if (cfg_we && cfg_index == CFG_SEGMENTS)
				seg_cfg <= cfg_wdata;
			else if (cfg_we && cfg_index == CFG_AXIS_ORDER)
				axis_cfg <= cfg_wdata[1:0];
			if (in_ch.valid && in_ch.ready)
				predict_tube(in_ch.near_axial, in_ch.near_radius, in_ch.far_axial,
					in_ch.far_radius, in_ch.centre_second, in_ch.centre_third);
			if (out_ch.valid && out_ch.ready) begin
				if (column_q.size() == 0) begin
					$error("column transfer with nothing expected");
					mismatches <= mismatches + 1;
				end else begin
					e = column_q.pop_front();
					bad = field_check("near_x", e.near_x, out_ch.near_x)
						+ field_check("near_y", e.near_y, out_ch.near_y)
						+ field_check("near_z", e.near_z, out_ch.near_z)
						+ field_check("far_x", e.far_x, out_ch.far_x)
						+ field_check("far_y", e.far_y, out_ch.far_y)
						+ field_check("far_z", e.far_z, out_ch.far_z)
						+ field_check("norm_x", e.norm_x, out_ch.norm_x)
						+ field_check("norm_y", e.norm_y, out_ch.norm_y)
						+ field_check("norm_z", e.norm_z, out_ch.norm_z)
						+ field_check("last", 16'(e.last), 16'(out_ch.last))
						+ field_check("bad_args", 16'(e.bad_args), 16'(out_ch.bad_args));
					mismatches <= mismatches + bad;
				end
			end
		end
	end

	assign columns_due = column_q.size();
endmodule

### test/tube_strip_vertex_generator_tb.sv
// Testbench top: clock, reset, tube stimulus, configuration phases and verdict.
module tube_strip_vertex_generator_tb import tsvg_pkg::*;;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [15:0] na, nr, fa, fr, cs, ct;
	} tube_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_wdata;
	int mismatches;
	int columns_due;
	int cycles;
	bit calm; // no idling on either side while set

	tsvg_in_if  in_ch();
	tsvg_out_if out_ch();

	tube_strip_vertex_generator u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	tsvg_column_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .columns_due(columns_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter: the run stops here if the block hangs
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tube_strip_vertex_generator_tb: done, errors");
				$finish;
			end
		end
	end

	// sink side: random stall before each column transfer
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// one tube transfer; valid stays high when the next gap is zero
	task automatic send_tube(input tube_t t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.near_axial <= t.na;
		in_ch.near_radius <= t.nr;
		in_ch.far_axial <= t.fa;
		in_ch.far_radius <= t.fr;
		in_ch.centre_second <= t.cs;
		in_ch.centre_third <= t.ct;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// drain, settle, then write one register
	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (columns_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic tube_t random_tube();
		tube_t t;
		t.na = 16'($urandom); t.nr = 16'($urandom); t.fa = 16'($urandom);
		t.fr = 16'($urandom); t.cs = 16'($urandom); t.ct = 16'($urandom);
		case ($urandom_range(0, 9))
			0: begin t.fa = t.na; t.fr = t.nr; end // degenerate ends
			1: t.fa = t.na;                        // flat annulus
			2: t.fr = t.nr;                        // straight cylinder
			3: begin t.nr = 16'h7fff; t.fr = 16'h8000; end
			default: ;
		endcase
		return t;
	endfunction

	function automatic tube_t mk(input int na, nr, fa, fr, cs, ct);
		tube_t t;
		t.na = 16'(na); t.nr = 16'(nr); t.fa = 16'(fa);
		t.fr = 16'(fr); t.cs = 16'(cs); t.ct = 16'(ct);
		return t;
	endfunction

	initial begin
		tube_t directed[$];
		int seg_plan[$];
		int n;
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SEGMENTS;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.near_axial <= '0;
		in_ch.near_radius <= '0;
		in_ch.far_axial <= '0;
		in_ch.far_radius <= '0;
		in_ch.centre_second <= '0;
		in_ch.centre_third <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tubes under the reset setting (8 segments, axial on x)
		directed = '{
			mk(0, 4096, 4096, 4096, 0, 0),            // unit cylinder
			mk(0, 4096, 0, 8192, 0, 0),               // flat annulus
			mk(0, 0, 4096, 4096, 0, 0),               // cone from a point
			mk(100, 200, 100, 200, 5, 5),             // degenerate ends
			mk(-32768, 32767, 32767, -32768, 32767, -32768),
			mk(32767, -32768, -32768, 32767, -32768, 32767),
			mk(0, 32767, 1, 32767, 32767, 32767),     // vertices saturate high
			mk(0, 32767, -1, 32767, -32768, -32768),  // and low
			mk(4096, -4096, -4096, -8192, 1234, -4321),
			mk(-1, -1, -1, -1, -1, -1)                // degenerate, all ones
		};
		foreach (directed[i])
			send_tube(directed[i]);

		// too few segments, then the extremes of the axis order
		write_reg(CFG_SEGMENTS, 6'd0);
		send_tube(mk(0, 4096, 4096, 4096, 0, 0));
		write_reg(CFG_SEGMENTS, 6'd2);
		send_tube(mk(0, 4096, 4096, 2048, 0, 0));
		write_reg(CFG_SEGMENTS, 6'd3);
		write_reg(CFG_UNUSED, 6'h3f);             // ignored index
		send_tube(mk(0, 4096, 4096, 2048, 100, -100));
		write_reg(CFG_AXIS_ORDER, 6'd1);
		send_tube(mk(-4096, 4096, 4096, 0, 300, 400));
		write_reg(CFG_AXIS_ORDER, 6'd2);
		send_tube(mk(-4096, 4096, 4096, 0, 300, 400));
		write_reg(CFG_AXIS_ORDER, 6'd3);          // acts as axial on x
		send_tube(mk(-4096, 4096, 4096, 0, 300, 400));

		// largest segment count, few tubes, full speed
		write_reg(CFG_SEGMENTS, 6'd63);
		calm = 1'b1;
		repeat (3)
			send_tube(random_tube());
		calm = 1'b0;

		// random phases: mostly small segment counts, occasional bad ones
		seg_plan = '{4, 5, 3, 7, 16, 1, 6, 9, 4, 12};
		foreach (seg_plan[p]) begin
			write_reg(CFG_SEGMENTS, 6'(seg_plan[p]));
			write_reg(CFG_AXIS_ORDER, 6'($urandom_range(0, 3)));
			calm = (p % 4 == 3);
			n = (seg_plan[p] > 10) ? 6 : 17;
			repeat (n)
				send_tube(random_tube());
		end
		calm = 1'b0;

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (columns_due != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tube_strip_vertex_generator_tb: done, clean");
		else
			$display("tube_strip_vertex_generator_tb: done, errors");
		$finish;
	end
endmodule

### tube_strip_vertex_generator.f
+incdir+sv
sv/tsvg_pkg.sv
sv/tsvg_if.sv
sv/tsvg_ctrl.sv
sv/tsvg_dp.sv
sv/tube_strip_vertex_generator.sv
sv/tsvg_checker.sv
test/tsvg_column_checker.sv
test/tube_strip_vertex_generator_tb.sv
